// ===== hdl/fixed_window_rate_limit_table_defines.svh =====
// Assertion macros used by the rate limit table controller.
`ifndef FIXED_WINDOW_RATE_LIMIT_TABLE_DEFINES_SVH
`define FIXED_WINDOW_RATE_LIMIT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FWRLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwrlt assertion failed");

// Next-cycle implication, disabled while in reset.
`define FWRLT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwrlt assertion failed");

`endif

// ===== hdl/fwrlt_pkg.sv =====
// Types and constants of the fixed-window rate limit table.
package fwrlt_pkg;

    // request codes
    localparam logic [1:0] REQ_CHECK  = 2'd0;
    localparam logic [1:0] REQ_RECORD = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_CREATED   = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int          SPAN_W       = 22;
    localparam logic [5:0]  SECS_PER_MIN = 6'd60;
    localparam logic [15:0] ATT_MAX      = 16'hFFFF;

    // one table record apart from the key
    typedef struct packed {
        logic [31:0] start;
        logic [15:0] attempts;
        logic [15:0] window;
        logic [15:0] limit;
    } rec_t;

    // memory strobes from the controller
    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic rec_we;
    } mem_ctl_t;

endpackage

// ===== hdl/fwrlt_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module fwrlt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fwrlt_ctrl.sv =====
// Search, update and result sequencer of the rate limit table.
`include "fixed_window_rate_limit_table_defines.svh"

module fwrlt_ctrl #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    // request side
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          req_type,
    input  logic [31:0]         key,
    input  logic [15:0]         max_attempts,
    input  logic [15:0]         window_minutes,
    input  logic [31:0]         now_seconds,
    // result side
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                limited,
    output logic [1:0]          status,
    // memories
    output fwrlt_pkg::mem_ctl_t mem_ctl,
    output logic [IW-1:0]       rd_addr,
    output logic [IW-1:0]       wr_addr,
    output logic [31:0]         key_wdata,
    output fwrlt_pkg::rec_t     rec_wdata,
    input  logic [31:0]         key_rdata,
    input  fwrlt_pkg::rec_t     rec_rdata
);

    typedef enum logic [2:0] {IDLE, SCAN, CALC, UPD, MISS, RESP} state_t;

    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    state_t                         state_reg;
    logic [ENTRIES-1:0]             valid_reg;
    logic [IW-1:0]                  iss_idx_reg;
    logic                           iss_act_reg;
    logic [IW-1:0]                  cmp_idx_reg;
    logic                           cmp_act_reg;
    logic [IW-1:0]                  hit_idx_reg;
    logic [IW-1:0]                  free_idx_reg;
    logic                           free_found_reg;
    logic                           res_limited_reg;
    logic [1:0]                     res_status_reg;
    logic                           out_valid_reg;
    logic                           out_limited_reg;
    logic [1:0]                     out_status_reg;

    // request and working record
    logic [1:0]                     req_reg;
    logic [31:0]                    key_reg;
    logic [15:0]                    lim_reg;
    logic [15:0]                    win_reg;
    logic [31:0]                    now_reg;
    fwrlt_pkg::rec_t                rec_reg;
    logic [fwrlt_pkg::SPAN_W-1:0]   span_reg;
    logic [31:0]                    elapsed_reg;

    logic                           accept;
    logic                           hit;
    logic                           restart;
    logic                           allocate;
    logic                           out_free;
    fwrlt_pkg::rec_t                upd_rec;

    assign s_tready = (state_reg == IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign hit = cmp_act_reg && valid_reg[cmp_idx_reg] && (key_rdata == key_reg);

    // window expired: strictly more than window*60 seconds gone
    assign restart  = elapsed_reg > {{(32 - fwrlt_pkg::SPAN_W){1'b0}}, span_reg};
    assign allocate = (state_reg == MISS) && (req_reg == fwrlt_pkg::REQ_CHECK) && free_found_reg;

    always_comb
    begin
        upd_rec = rec_reg;
        case (req_reg)
            fwrlt_pkg::REQ_CHECK:
            begin
                if (restart)
                begin
                    upd_rec.attempts = '0;
                    upd_rec.start    = now_reg;
                end
            end
            fwrlt_pkg::REQ_RECORD:
            begin
                if (rec_reg.attempts != fwrlt_pkg::ATT_MAX)
                begin
                    upd_rec.attempts = rec_reg.attempts + 16'd1;
                end
            end
            default:
            begin
                upd_rec = rec_reg;
            end
        endcase
    end

    always_comb
    begin
        mem_ctl.rd_en  = (state_reg == SCAN) && iss_act_reg;
        mem_ctl.key_we = allocate;
        mem_ctl.rec_we = allocate
                      || ((state_reg == UPD)
                          && ((req_reg == fwrlt_pkg::REQ_CHECK)
                              || (req_reg == fwrlt_pkg::REQ_RECORD)));
        rd_addr   = iss_idx_reg;
        wr_addr   = (state_reg == MISS) ? free_idx_reg : hit_idx_reg;
        key_wdata = key_reg;
        if (state_reg == MISS)
        begin
            rec_wdata.start    = now_reg;
            rec_wdata.attempts = '0;
            rec_wdata.window   = win_reg;
            rec_wdata.limit    = lim_reg;
        end
        else
        begin
            rec_wdata = upd_rec;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            key_reg <= key;
            lim_reg <= max_attempts;
            win_reg <= window_minutes;
            now_reg <= now_seconds;
        end
        if ((state_reg == SCAN) && hit)
        begin
            rec_reg <= rec_rdata;
        end
        if (state_reg == CALC)
        begin
            span_reg    <= fwrlt_pkg::SPAN_W'(rec_reg.window)
                         * fwrlt_pkg::SPAN_W'(fwrlt_pkg::SECS_PER_MIN);
            elapsed_reg <= now_reg - rec_reg.start;
        end
    end

    // state machine and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            valid_reg       <= '0;
            iss_idx_reg     <= '0;
            iss_act_reg     <= 1'b0;
            cmp_idx_reg     <= '0;
            cmp_act_reg     <= 1'b0;
            hit_idx_reg     <= '0;
            free_idx_reg    <= '0;
            free_found_reg  <= 1'b0;
            res_limited_reg <= 1'b0;
            res_status_reg  <= fwrlt_pkg::ST_NOT_FOUND;
            out_valid_reg   <= 1'b0;
            out_limited_reg <= 1'b0;
            out_status_reg  <= fwrlt_pkg::ST_NOT_FOUND;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg      <= SCAN;
                        iss_idx_reg    <= '0;
                        iss_act_reg    <= 1'b1;
                        cmp_act_reg    <= 1'b0;
                        free_found_reg <= 1'b0;
                    end
                end
                SCAN:
                begin
                    cmp_act_reg <= iss_act_reg;
                    cmp_idx_reg <= iss_idx_reg;
                    if (iss_act_reg)
                    begin
                        iss_act_reg <= (iss_idx_reg != LAST_IDX);
                        if (iss_idx_reg != LAST_IDX)
                        begin
                            iss_idx_reg <= iss_idx_reg + 1'b1;
                        end
                    end
                    if (cmp_act_reg)
                    begin
                        if (hit)
                        begin
                            hit_idx_reg <= cmp_idx_reg;
                            iss_act_reg <= 1'b0;
                            state_reg   <= CALC;
                        end
                        else
                        begin
                            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                            begin
                                free_idx_reg   <= cmp_idx_reg;
                                free_found_reg <= 1'b1;
                            end
                            if (cmp_idx_reg == LAST_IDX)
                            begin
                                state_reg <= MISS;
                            end
                        end
                    end
                end
                CALC:
                begin
                    state_reg <= UPD;
                end
                UPD:
                begin
                    res_limited_reg <= (req_reg == fwrlt_pkg::REQ_CHECK)
                                    && (upd_rec.attempts >= upd_rec.limit);
                    if ((req_reg == fwrlt_pkg::REQ_CHECK)
                        || (req_reg == fwrlt_pkg::REQ_RECORD)
                        || (req_reg == fwrlt_pkg::REQ_REMOVE))
                    begin
                        res_status_reg <= fwrlt_pkg::ST_FOUND;
                    end
                    else
                    begin
                        res_status_reg <= fwrlt_pkg::ST_NOT_FOUND;
                    end
                    if (req_reg == fwrlt_pkg::REQ_REMOVE)
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                    end
                    state_reg <= RESP;
                end
                MISS:
                begin
                    res_limited_reg <= 1'b0;
                    if (req_reg == fwrlt_pkg::REQ_CHECK)
                    begin
                        res_status_reg <= free_found_reg ? fwrlt_pkg::ST_CREATED
                                                         : fwrlt_pkg::ST_FULL;
                    end
                    else
                    begin
                        res_status_reg <= fwrlt_pkg::ST_NOT_FOUND;
                    end
                    if (allocate)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                    end
                    state_reg <= RESP;
                end
                RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_limited_reg <= res_limited_reg;
                        out_status_reg  <= res_status_reg;
                        state_reg       <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign limited  = out_limited_reg;
    assign status   = out_status_reg;

    // a new key only ever lands in a free slot
    `FWRLT_ASSERT_NOW(a_alloc_free_slot, clk, rst_n, mem_ctl.key_we, !valid_reg[wr_addr])
    // the remembered free slot stays free until it is used
    `FWRLT_ASSERT_NOW(a_free_slot_held, clk, rst_n,
        ((state_reg == SCAN) || (state_reg == MISS)) && free_found_reg,
        !valid_reg[free_idx_reg])
    // memory reads only while searching
    `FWRLT_ASSERT_NOW(a_read_in_scan, clk, rst_n, mem_ctl.rd_en, state_reg == SCAN)
    // a finished request always reaches the result register
    `FWRLT_ASSERT_NXT(a_resp_delivers, clk, rst_n,
        (state_reg == RESP) && out_free, out_valid_reg && (state_reg == IDLE))
    // a table-full answer only comes from a check that found no free slot
    `FWRLT_ASSERT_NXT(a_full_only_check, clk, rst_n,
        (state_reg == MISS) && free_found_reg, res_status_reg != fwrlt_pkg::ST_FULL)

endmodule

// ===== hdl/fixed_window_rate_limit_table.sv =====
// Top level of the fixed-window rate limit table.
//
//  channel  | signals                  | direction | contents
//  ---------+--------------------------+-----------+-------------------------------------
//  s_       | tvalid tready tdata tuser| in        | one request: key, limit, window, time
//  m_       | tvalid tready tdata tuser| out       | one result: limited flag and status
//
// A request is accepted only after the previous one has finished. The search
// stops at the slot that holds the key; an absent key is compared against all
// ENTRIES slots. The search reads one key and one record per cycle from the
// single read port of the key and record memories and compares one key a cycle.
// Reset clears the slot valid bits at once; the memories need no clearing pass.
// A result waits in the output register while the next request is accepted and
// searched; a request whose result finds that register still full waits in its
// last step until the result side takes the previous one.
module fixed_window_rate_limit_table #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key[31:0], max_attempts[47:32],
                                   // window_minutes[63:48], now_seconds[95:64]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // limited[0], zero fill[7:1]
    output logic [1:0]  m_tuser    // status[1:0]
);

    // slot index width; one bit even for a single-slot table
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    fwrlt_pkg::mem_ctl_t mem_ctl;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       wr_addr;
    logic [31:0]         key_wdata;
    logic [31:0]         key_rdata;
    fwrlt_pkg::rec_t     rec_wdata;
    fwrlt_pkg::rec_t     rec_rdata;
    logic                limited;

    // sequencer: search, window check, update and result register
    fwrlt_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .req_type       (s_tuser),
        .key            (s_tdata[31:0]),
        .max_attempts   (s_tdata[47:32]),
        .window_minutes (s_tdata[63:48]),
        .now_seconds    (s_tdata[95:64]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .limited        (limited),
        .status         (m_tuser),
        .mem_ctl        (mem_ctl),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr),
        .key_wdata      (key_wdata),
        .rec_wdata      (rec_wdata),
        .key_rdata      (key_rdata),
        .rec_rdata      (rec_rdata)
    );

    // keys, searched one slot per cycle
    fwrlt_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (32),
        .AW    (IW)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_ctl.key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .re    (mem_ctl.rd_en),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    // limit, window, attempt count and window start, read alongside the key
    fwrlt_ram #(
        .DEPTH (ENTRIES),
        .WIDTH ($bits(fwrlt_pkg::rec_t)),
        .AW    (IW)
    ) u_rec_ram (
        .clk   (clk),
        .we    (mem_ctl.rec_we),
        .waddr (wr_addr),
        .wdata (rec_wdata),
        .re    (mem_ctl.rd_en),
        .raddr (rd_addr),
        .rdata (rec_rdata)
    );

    assign m_tdata = {7'b0, limited};

endmodule

// ===== bench/tb_fixed_window_rate_limit_table.sv =====
// Self-checking testbench for the fixed-window rate limit table.
module tb_fixed_window_rate_limit_table;

    localparam logic [1:0] REQ_CHECK    = fwrlt_pkg::REQ_CHECK;
    localparam logic [1:0] REQ_RECORD   = fwrlt_pkg::REQ_RECORD;
    localparam logic [1:0] REQ_REMOVE   = fwrlt_pkg::REQ_REMOVE;
    localparam logic [1:0] ST_CREATED   = fwrlt_pkg::ST_CREATED;
    localparam logic [1:0] ST_FOUND     = fwrlt_pkg::ST_FOUND;
    localparam logic [1:0] ST_NOT_FOUND = fwrlt_pkg::ST_NOT_FOUND;
    localparam logic [1:0] ST_FULL      = fwrlt_pkg::ST_FULL;

    localparam int SLOTS = 16;
    // code the block leaves unused; it must answer key not found
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_REQUESTS = 1850;
    localparam int KEY_POOL = 24;

    // one directed row; typed rows carry their own expected answer
    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] key;
        logic [15:0] lim;
        logic [15:0] win;
        logic [31:0] now;
        logic        typed;
        logic        hit;
        logic [1:0]  st;
    } row_t;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] key;
        logic        hit;
        logic [1:0]  st;
    } answer_t;

    localparam int ROWS = 21;
    localparam row_t DIRECTED [ROWS] = '{
        // absent keys on an empty table, unused code with every field high
        '{REQ_REMOVE, 32'h0000_0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, ST_NOT_FOUND},
        '{REQ_RECORD, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, ST_NOT_FOUND},
        '{REQ_UNUSED, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_NOT_FOUND},
        // zero limit, zero window: limited from the first check after it is created
        '{REQ_CHECK,  32'h0000_0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, ST_CREATED},
        '{REQ_CHECK,  32'h0000_0000, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b1, ST_FOUND},
        '{REQ_RECORD, 32'h0000_0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, ST_FOUND},
        // zero window restarts once any time has passed
        '{REQ_CHECK,  32'h0000_0000, 16'h0000, 16'h0000, 32'h0000_0001, 1'b0, 1'b0, ST_FOUND},
        // all-ones fields, then a time that wrapped past zero
        '{REQ_CHECK,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_CREATED},
        '{REQ_RECORD, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_FOUND},
        '{REQ_CHECK,  32'hFFFF_FFFF, 16'h0000, 16'h0000, 32'h0000_0005, 1'b0, 1'b0, ST_FOUND},
        // one minute window: exactly 60 s keeps the count, 61 s restarts it
        '{REQ_CHECK,  32'h0000_0005, 16'h0002, 16'h0001, 32'd100,       1'b1, 1'b0, ST_CREATED},
        '{REQ_RECORD, 32'h0000_0005, 16'h0000, 16'h0000, 32'd100,       1'b1, 1'b0, ST_FOUND},
        '{REQ_RECORD, 32'h0000_0005, 16'h0000, 16'h0000, 32'd100,       1'b1, 1'b0, ST_FOUND},
        '{REQ_CHECK,  32'h0000_0005, 16'h0000, 16'h0000, 32'd160,       1'b0, 1'b0, ST_FOUND},
        '{REQ_CHECK,  32'h0000_0005, 16'h0000, 16'h0000, 32'd161,       1'b0, 1'b0, ST_FOUND},
        // removal, then the freed slot is taken again
        '{REQ_REMOVE, 32'h0000_0005, 16'h0000, 16'h0000, 32'd161,       1'b1, 1'b0, ST_FOUND},
        '{REQ_RECORD, 32'h0000_0005, 16'h0000, 16'h0000, 32'd161,       1'b1, 1'b0, ST_NOT_FOUND},
        '{REQ_CHECK,  32'h0000_0005, 16'h0001, 16'h0000, 32'd200,       1'b1, 1'b0, ST_CREATED},
        '{REQ_REMOVE, 32'h0000_0000, 16'h0000, 16'h0000, 32'd200,       1'b1, 1'b0, ST_FOUND},
        '{REQ_CHECK,  32'h8000_0000, 16'h8000, 16'h8000, 32'h8000_0000, 1'b0, 1'b0, ST_CREATED},
        // unused code on a present key still finds nothing
        '{REQ_UNUSED, 32'h0000_0005, 16'h0000, 16'h0000, 32'h8000_0000, 1'b1, 1'b0, ST_NOT_FOUND}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    // shadow copy of the limit table
    bit          tbl_used [SLOTS];
    logic [31:0] tbl_key [SLOTS];
    logic [15:0] tbl_limit [SLOTS];
    logic [15:0] tbl_window [SLOTS];
    logic [15:0] tbl_attempts [SLOTS];
    logic [31:0] tbl_start [SLOTS];

    answer_t owed_answers [$];
    int      mismatch_count = 0;
    int      quiet_cycles = 0;

    // sender and receiver pacing
    bit      rush = 1'b0;
    bit      gaps_on = 1'b1;
    int      burst_left = 0;
    int      rx_mode = 1;
    int      rx_wait = 0;
    int      rx_cycle = 0;

    fixed_window_rate_limit_table #(.ENTRIES(SLOTS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Apply one request to the shadow table and return the answer it earns.
    function automatic void rate_table_step(input logic [1:0] req, input logic [31:0] key,
                                            input logic [15:0] lim, input logic [15:0] win,
                                            input logic [31:0] now,
                                            output logic hit, output logic [1:0] st);
        int          idx;
        int          free_idx;
        logic [31:0] elapsed;
        logic [31:0] span;
        idx = -1;
        free_idx = -1;
        hit = 1'b0;
        st = ST_NOT_FOUND;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (tbl_used[i] && tbl_key[i] == key)
                idx = i;
            if (!tbl_used[i])
                free_idx = i;
        end
        if (req == REQ_CHECK)
        begin
            if (idx < 0 && free_idx < 0)
                st = ST_FULL;
            else if (idx < 0)
            begin
                tbl_used[free_idx] = 1'b1;
                tbl_key[free_idx] = key;
                tbl_limit[free_idx] = lim;
                tbl_window[free_idx] = win;
                tbl_attempts[free_idx] = '0;
                tbl_start[free_idx] = now;
                st = ST_CREATED;
            end
            else
            begin
                elapsed = now - tbl_start[idx];
                span = {16'd0, tbl_window[idx]} * 32'd60;
                if (elapsed > span)
                begin
                    tbl_attempts[idx] = '0;
                    tbl_start[idx] = now;
                end
                hit = (tbl_attempts[idx] >= tbl_limit[idx]);
                st = ST_FOUND;
            end
        end
        else if (req == REQ_RECORD && idx >= 0)
        begin
            if (tbl_attempts[idx] != 16'hFFFF)
                tbl_attempts[idx] = tbl_attempts[idx] + 16'd1;
            st = ST_FOUND;
        end
        else if (req == REQ_REMOVE && idx >= 0)
        begin
            tbl_used[idx] = 1'b0;
            st = ST_FOUND;
        end
    endfunction

    // Drive one request from the falling edge until it is taken, then log its answer.
    task automatic send_request(input logic [1:0] req, input logic [31:0] key,
                                input logic [15:0] lim, input logic [15:0] win,
                                input logic [31:0] now, input logic typed,
                                input logic t_hit, input logic [1:0] t_st);
        int      gap;
        answer_t ans;
        @(negedge clk);
        if (!rush && burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 25) : 0;
            if (gap != 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid = 1'b1;
        s_tdata = {now, win, lim, key};
        s_tuser = req;
        do
            @(posedge clk);
        while (!s_tready);
        ans.req = req;
        ans.key = key;
        rate_table_step(req, key, lim, win, now, ans.hit, ans.st);
        if (typed)
        begin
            ans.hit = t_hit;
            ans.st = t_st;
        end
        owed_answers.push_back(ans);
    endtask

    // Receiver: ready is always high, or paced by short or long random waits; the pattern is redrawn now and again.
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 2500 == 2499)
            rx_mode <= $urandom_range(0, 2);
        if (rush || rx_mode == 0)
            m_tready <= 1'b1;
        else if (rx_wait != 0)
        begin
            m_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_wait <= (rx_mode == 1) ? $urandom_range(0, 3) : $urandom_range(0, 30);
        end
    end

    // Result checker: every taken result against the oldest owed answer.
    always @(posedge clk)
    begin
        answer_t exp_ans;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (owed_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: limited %0b status %0d",
                             m_tdata[0], m_tuser);
            end
            else
            begin
                exp_ans = owed_answers.pop_front();
                if (m_tdata[0] !== exp_ans.hit || m_tuser !== exp_ans.st)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch req %0d key %h: limited %0b/%0b status %0d/%0d",
                                 exp_ans.req, exp_ans.key, exp_ans.hit, m_tdata[0],
                                 exp_ans.st, m_tuser);
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_fixed_window_rate_limit_table: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] key_pool [KEY_POOL];
        logic [31:0] now_s;
        logic [31:0] key;
        logic [15:0] lim;
        logic [15:0] win;
        logic [1:0]  req;
        int          roll;
        for (int i = 0; i < SLOTS; i++)
            tbl_used[i] = 1'b0;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Flat out, entry in the first slot: three attempts on a limit of
        // three read as limited.
        rush = 1'b1;
        send_request(REQ_CHECK, 32'hA5A5_0001, 16'd3, 16'hFFFF, 32'd1000,
                     1'b1, 1'b0, ST_CREATED);
        for (int i = 0; i < 3; i++)
            send_request(REQ_RECORD, 32'hA5A5_0001, 16'h0000, 16'h0000, 32'd1000,
                         1'b1, 1'b0, ST_FOUND);
        send_request(REQ_CHECK, 32'hA5A5_0001, 16'h0000, 16'h0000, 32'd1000,
                     1'b1, 1'b1, ST_FOUND);
        send_request(REQ_REMOVE, 32'hA5A5_0001, 16'h0000, 16'h0000, 32'd1000,
                     1'b1, 1'b0, ST_FOUND);
        rush = 1'b0;

        for (int r = 0; r < ROWS; r++)
            send_request(DIRECTED[r].req, DIRECTED[r].key, DIRECTED[r].lim,
                         DIRECTED[r].win, DIRECTED[r].now, DIRECTED[r].typed,
                         DIRECTED[r].hit, DIRECTED[r].st);

        // fill the remaining slots, then ask for one more: table full
        for (int i = 0; i < SLOTS; i++)
            if (!tbl_used[i])
                send_request(REQ_CHECK, 32'h0000_0100 + i, 16'd3, 16'd1, 32'h8000_0000,
                             1'b0, 1'b0, ST_CREATED);
        send_request(REQ_CHECK, 32'h0000_0200, 16'd3, 16'd1, 32'h8000_0000,
                     1'b1, 1'b0, ST_FULL);

        // empty the table so the random traffic starts from free slots
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i])
                send_request(REQ_REMOVE, tbl_key[i], 16'h0000, 16'h0000, 32'h8000_0000,
                             1'b1, 1'b0, ST_FOUND);

        // Random traffic: a pool of keys larger than the table keeps it near
        // full; small time steps against short windows exercise both the
        // limited answer and window restarts.
        now_s = $urandom;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 150 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 45)
                req = REQ_CHECK;
            else if (roll < 80)
                req = REQ_RECORD;
            else if (roll < 96)
                req = REQ_REMOVE;
            else
                req = REQ_UNUSED;
            key = ($urandom_range(0, 19) == 0) ? $urandom : key_pool[$urandom_range(0, KEY_POOL - 1)];
            lim = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
            win = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
            roll = $urandom_range(0, 99);
            if (roll < 70)
                now_s = now_s + $urandom_range(0, 6);
            else if (roll < 97)
                now_s = now_s + $urandom_range(7, 240);
            else
                now_s = $urandom;
            send_request(req, key, lim, win, now_s, 1'b0, 1'b0, ST_CREATED);
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (owed_answers.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_fixed_window_rate_limit_table: PASS");
        else
            $display("tb_fixed_window_rate_limit_table: FAIL");
        $finish;
    end

endmodule
